[rtl/core/pswf_pkg.sv]
// Shared types and constants for the pulse source waveform block.
`default_nettype none

package pswf_pkg;

    // Width of the completed-period counter.
    localparam int COUNT_WIDTH = 32;

    // Depth of the command queue between the classifier and the ramp engine.
    localparam int QUEUE_DEPTH = 2;

    // What the classifier decided for one timestamp.
    typedef enum logic [1:0] {
        CMD_LOW       = 2'd0,
        CMD_HIGH      = 2'd1,
        CMD_RAMP_UP   = 2'd2,
        CMD_RAMP_DOWN = 2'd3
    } cmd_kind_t;

endpackage

`default_nettype wire

[rtl/core/pswf_front.sv]
// Request classifier: period tracking and phase selection for each timestamp.
`default_nettype none

module pswf_front #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic [TIME_WIDTH-1:0]    sim_time,
    input  wire logic                     delay_load,
    input  wire logic [TIME_WIDTH-1:0]    delay_value,
    input  wire logic [TIME_WIDTH-1:0]    delay_time,
    input  wire logic [TIME_WIDTH-1:0]    rise_time,
    input  wire logic [TIME_WIDTH-1:0]    pulse_width,
    input  wire logic [TIME_WIDTH-1:0]    fall_time,
    input  wire logic [TIME_WIDTH-1:0]    period_length,
    output logic                          cmd_valid,
    input  wire logic                     cmd_full,
    output pswf_pkg::cmd_kind_t           cmd_kind,
    output logic [TIME_WIDTH-1:0]         cmd_elapsed,
    output logic [TIME_WIDTH-1:0]         cmd_dur
);
    import pswf_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_ADV  = 6'b000010,
        F_RISE = 6'b000100,
        F_HOLD = 6'b001000,
        F_FALL = 6'b010000,
        F_PUSH = 6'b100000
    } front_state_t;

    front_state_t              state_reg, state_next;
    logic [TIME_WIDTH-1:0]     time_reg, time_next;
    logic [TIME_WIDTH-1:0]     start_reg, start_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [TIME_WIDTH-1:0]     edge_reg, edge_next;
    cmd_kind_t                 kind_reg, kind_next;
    logic [TIME_WIDTH-1:0]     elapsed_reg, elapsed_next;
    logic [TIME_WIDTH-1:0]     dur_reg, dur_next;

    logic [TIME_WIDTH-1:0]     add_a;
    logic [TIME_WIDTH-1:0]     add_b;
    logic [TIME_WIDTH:0]       add_full;
    logic [TIME_WIDTH-1:0]     add_sum;

    // One saturating adder, shared by every phase end.
    always_comb
    begin
        case (state_reg)
            F_ADV:
            begin
                add_a = start_reg;
                add_b = period_length;
            end
            F_RISE:
            begin
                add_a = start_reg;
                add_b = rise_time;
            end
            F_HOLD:
            begin
                add_a = edge_reg;
                add_b = pulse_width;
            end
            default:
            begin
                add_a = edge_reg;
                add_b = fall_time;
            end
        endcase
        add_full = {1'b0, add_a} + {1'b0, add_b};
        add_sum  = add_full[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : add_full[TIME_WIDTH-1:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        time_next    = time_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        edge_next    = edge_reg;
        kind_next    = kind_reg;
        elapsed_next = elapsed_reg;
        dur_next     = dur_reg;

        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    time_next  = sim_time;
                    state_next = F_ADV;
                end
            end
            F_ADV:
            begin
                // advance the period start by at most one period
                if (time_reg >= add_sum)
                begin
                    start_next = add_sum;
                    if (count_reg != {COUNT_WIDTH{1'b1}})
                    begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                end
                state_next = F_RISE;
            end
            F_RISE:
            begin
                if (time_reg <= delay_time || time_reg < start_reg)
                begin
                    kind_next  = CMD_LOW;
                    state_next = F_PUSH;
                end
                else if (time_reg <= add_sum)
                begin
                    kind_next    = CMD_RAMP_UP;
                    elapsed_next = time_reg - start_reg;
                    dur_next     = rise_time;
                    state_next   = F_PUSH;
                end
                else
                begin
                    edge_next  = add_sum;
                    state_next = F_HOLD;
                end
            end
            F_HOLD:
            begin
                if (time_reg <= add_sum)
                begin
                    kind_next  = CMD_HIGH;
                    state_next = F_PUSH;
                end
                else
                begin
                    edge_next  = add_sum;
                    state_next = F_FALL;
                end
            end
            F_FALL:
            begin
                if (time_reg <= add_sum)
                begin
                    kind_next    = CMD_RAMP_DOWN;
                    elapsed_next = time_reg - edge_reg;
                    dur_next     = fall_time;
                end
                else
                begin
                    kind_next = CMD_LOW;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!cmd_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        // a new delay restarts the waveform
        if (delay_load)
        begin
            start_next = delay_value;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            start_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg    <= time_next;
        edge_reg    <= edge_next;
        kind_reg    <= kind_next;
        elapsed_reg <= elapsed_next;
        dur_reg     <= dur_next;
    end

    assign full        = (state_reg != F_IDLE);
    assign cmd_valid   = (state_reg == F_PUSH);
    assign cmd_kind    = kind_reg;
    assign cmd_elapsed = elapsed_reg;
    assign cmd_dur     = dur_reg;

endmodule

`default_nettype wire

[rtl/core/pswf_queue.sv]
// Short command queue between the classifier and the ramp engine.
`default_nettype none

module pswf_queue #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire pswf_pkg::cmd_kind_t      push_kind,
    input  wire logic [TIME_WIDTH-1:0]    push_elapsed,
    input  wire logic [TIME_WIDTH-1:0]    push_dur,
    input  wire logic                     pop,
    output logic                          empty,
    output pswf_pkg::cmd_kind_t           pop_kind,
    output logic [TIME_WIDTH-1:0]         pop_elapsed,
    output logic [TIME_WIDTH-1:0]         pop_dur
);
    import pswf_pkg::*;

    localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    cmd_kind_t                 kind_mem    [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0]     elapsed_mem [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0]     dur_mem     [QUEUE_DEPTH];

    logic [PTR_WIDTH-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0]      count_reg, count_next;
    logic                      do_push;
    logic                      do_pop;

    assign full    = (count_reg == CNT_WIDTH'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_WIDTH'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_WIDTH'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_WIDTH'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            kind_mem[wr_ptr_reg]    <= push_kind;
            elapsed_mem[wr_ptr_reg] <= push_elapsed;
            dur_mem[wr_ptr_reg]     <= push_dur;
        end
    end

    assign pop_kind    = kind_mem[rd_ptr_reg];
    assign pop_elapsed = elapsed_mem[rd_ptr_reg];
    assign pop_dur     = dur_mem[rd_ptr_reg];

endmodule

`default_nettype wire

[rtl/core/pswf_back.sv]
// Ramp engine: bit-serial multiply-divide and the result register.
`default_nettype none

module pswf_back #(
    parameter int TIME_WIDTH  = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cmd_empty,
    output logic                           cmd_pop,
    input  wire pswf_pkg::cmd_kind_t       cmd_kind,
    input  wire logic [TIME_WIDTH-1:0]     cmd_elapsed,
    input  wire logic [TIME_WIDTH-1:0]     cmd_dur,
    input  wire logic [VALUE_WIDTH-1:0]    low_level,
    input  wire logic [VALUE_WIDTH-1:0]    high_level,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [VALUE_WIDTH-1:0]         source_value
);
    import pswf_pkg::*;

    localparam int MAG_WIDTH = VALUE_WIDTH + 1;
    localparam int CW        = $clog2(MAG_WIDTH + 1);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_RUN  = 4'b0010,
        B_FIN  = 4'b0100,
        B_DONE = 4'b1000
    } back_state_t;

    back_state_t               state_reg, state_next;
    logic [VALUE_WIDTH-1:0]    from_reg, from_next;
    logic                      neg_reg, neg_next;
    logic [MAG_WIDTH-1:0]      mag_reg, mag_next;
    logic [TIME_WIDTH-1:0]     e_reg, e_next;
    logic [TIME_WIDTH-1:0]     d_reg, d_next;
    logic [MAG_WIDTH-1:0]      q_reg, q_next;
    logic [TIME_WIDTH-1:0]     r_reg, r_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0]    res_reg, res_next;
    logic                      out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0]    out_value_reg, out_value_next;

    logic [VALUE_WIDTH-1:0]    ramp_from;
    logic [VALUE_WIDTH-1:0]    ramp_to;
    logic                      ramp_neg;
    logic [MAG_WIDTH-1:0]      up_mag;
    logic [MAG_WIDTH-1:0]      down_mag;

    logic [TIME_WIDTH+1:0]     step_sum;
    logic [TIME_WIDTH+1:0]     d_one;
    logic [TIME_WIDTH+1:0]     d_two;
    logic [TIME_WIDTH+1:0]     sub_one;
    logic [TIME_WIDTH+1:0]     sub_two;
    logic [1:0]                step_digit;
    logic [MAG_WIDTH-1:0]      from_ext;
    logic [MAG_WIDTH-1:0]      final_sum;
    logic                      load_out;

    // Ramp end points and the magnitude of the swing.
    always_comb
    begin
        if (cmd_kind == CMD_RAMP_DOWN)
        begin
            ramp_from = high_level;
            ramp_to   = low_level;
        end
        else
        begin
            ramp_from = low_level;
            ramp_to   = high_level;
        end
        ramp_neg = ($signed(ramp_to) < $signed(ramp_from));
        up_mag   = {ramp_to[VALUE_WIDTH-1], ramp_to} - {ramp_from[VALUE_WIDTH-1], ramp_from};
        down_mag = {ramp_from[VALUE_WIDTH-1], ramp_from} - {ramp_to[VALUE_WIDTH-1], ramp_to};
    end

    // One step of floor(mag * e / d): take the next bit of mag, keep the remainder below d.
    always_comb
    begin
        step_sum = {1'b0, r_reg, 1'b0}
                   + (mag_reg[MAG_WIDTH-1] ? {2'b00, e_reg} : '0);
        d_one    = {2'b00, d_reg};
        d_two    = {1'b0, d_reg, 1'b0};
        sub_one  = step_sum - d_one;
        sub_two  = step_sum - d_two;
        if (step_sum >= d_two)
        begin
            step_digit = 2'd2;
        end
        else if (step_sum >= d_one)
        begin
            step_digit = 2'd1;
        end
        else
        begin
            step_digit = 2'd0;
        end
        from_ext  = {from_reg[VALUE_WIDTH-1], from_reg};
        final_sum = neg_reg ? (from_ext - q_reg) : (from_ext + q_reg);
    end

    assign load_out = (state_reg == B_DONE) && (!out_valid_reg || pop);

    always_comb
    begin
        state_next     = state_reg;
        from_next      = from_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        e_next         = e_reg;
        d_next         = d_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        cmd_pop        = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_kind)
                        CMD_LOW:
                        begin
                            res_next   = low_level;
                            state_next = B_DONE;
                        end
                        CMD_HIGH:
                        begin
                            res_next   = high_level;
                            state_next = B_DONE;
                        end
                        default:
                        begin
                            if (cmd_dur == '0)
                            begin
                                res_next   = ramp_to;
                                state_next = B_DONE;
                            end
                            else
                            begin
                                from_next  = ramp_from;
                                neg_next   = ramp_neg;
                                mag_next   = ramp_neg ? down_mag : up_mag;
                                e_next     = cmd_elapsed;
                                d_next     = cmd_dur;
                                q_next     = '0;
                                r_next     = '0;
                                cnt_next   = CW'(MAG_WIDTH);
                                state_next = B_RUN;
                            end
                        end
                    endcase
                end
            end
            B_RUN:
            begin
                mag_next = {mag_reg[MAG_WIDTH-2:0], 1'b0};
                q_next   = {q_reg[MAG_WIDTH-2:0], 1'b0} + MAG_WIDTH'(step_digit);
                case (step_digit)
                    2'd2:    r_next = sub_two[TIME_WIDTH-1:0];
                    2'd1:    r_next = sub_one[TIME_WIDTH-1:0];
                    default: r_next = step_sum[TIME_WIDTH-1:0];
                endcase
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                res_next   = final_sum[VALUE_WIDTH-1:0];
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_value_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg      <= from_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        e_reg         <= e_next;
        d_reg         <= d_next;
        q_reg         <= q_next;
        r_reg         <= r_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
    end

    assign empty        = !out_valid_reg;
    assign source_value = out_value_reg;

endmodule

`default_nettype wire

[rtl/core/pulse_source_waveform.sv]
// Top level of the trapezoidal pulse source: register file, classifier, queue, ramp engine.
// The classifier takes a new request only once its last command is in the queue; a ramp holds
// the divider loop until its quotient is done, which limits the sustained rate of ramp requests.
// Reset: config registers and period start read zero, the queue and result register are empty.
// Writing the delay register also restarts the period tracking.
`default_nettype none

module pulse_source_waveform #(
    parameter int TIME_WIDTH  = 32,
    parameter int VALUE_WIDTH = 32,
    localparam int DATA_WIDTH = (TIME_WIDTH > 32 || VALUE_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB   = (DATA_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_WIDTH = ADDR_LSB + 3
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // request side
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [TIME_WIDTH-1:0]     sim_time,
    // result side
    output logic                           empty,
    input  wire logic                      pop,
    output logic [VALUE_WIDTH-1:0]         source_value,
    // configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_WIDTH-1:0]     paddr,
    input  wire logic [DATA_WIDTH-1:0]     pwdata,
    output logic [DATA_WIDTH-1:0]          prdata,
    output logic                           pready
);
    import pswf_pkg::*;

    typedef enum logic [2:0] {
        REG_DELAY  = 3'd0,
        REG_RISE   = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_FALL   = 3'd3,
        REG_PERIOD = 3'd4,
        REG_LOW    = 3'd5,
        REG_HIGH   = 3'd6
    } reg_idx_t;

    logic [TIME_WIDTH-1:0]     delay_reg;
    logic [TIME_WIDTH-1:0]     rise_reg;
    logic [TIME_WIDTH-1:0]     width_reg;
    logic [TIME_WIDTH-1:0]     fall_reg;
    logic [TIME_WIDTH-1:0]     period_reg;
    logic [VALUE_WIDTH-1:0]    low_reg;
    logic [VALUE_WIDTH-1:0]    high_reg;

    logic [2:0]                reg_idx;
    logic                      cfg_write;
    logic                      delay_load;
    logic [TIME_WIDTH-1:0]     wr_time;
    logic [VALUE_WIDTH-1:0]    wr_value;

    // classifier to queue
    logic                      f_cmd_valid;
    logic                      q_full;
    cmd_kind_t                 f_kind;
    logic [TIME_WIDTH-1:0]     f_elapsed;
    logic [TIME_WIDTH-1:0]     f_dur;

    // queue to ramp engine
    logic                      q_empty;
    logic                      q_pop;
    cmd_kind_t                 q_kind;
    logic [TIME_WIDTH-1:0]     q_elapsed;
    logic [TIME_WIDTH-1:0]     q_dur;

    // ------------------------------------------------------------------
    // Configuration registers. The access phase always completes at once.
    // ------------------------------------------------------------------
    assign pready     = 1'b1;
    assign reg_idx    = paddr[ADDR_WIDTH-1:ADDR_LSB];
    assign cfg_write  = psel && penable && pwrite && pready;
    assign wr_time    = pwdata[TIME_WIDTH-1:0];
    assign wr_value   = pwdata[VALUE_WIDTH-1:0];
    assign delay_load = cfg_write && (reg_idx == REG_DELAY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= '0;
            rise_reg   <= '0;
            width_reg  <= '0;
            fall_reg   <= '0;
            period_reg <= '0;
            low_reg    <= '0;
            high_reg   <= '0;
        end
        else if (cfg_write)
        begin
            // drop writes to addresses past the last register
            case (reg_idx)
                REG_DELAY:  delay_reg  <= wr_time;
                REG_RISE:   rise_reg   <= wr_time;
                REG_WIDTH:  width_reg  <= wr_time;
                REG_FALL:   fall_reg   <= wr_time;
                REG_PERIOD: period_reg <= wr_time;
                REG_LOW:    low_reg    <= wr_value;
                REG_HIGH:   high_reg   <= wr_value;
                default:    ;
            endcase
        end
    end

    // Read back the raw register bits, zero-extended to the bus.
    always_comb
    begin
        case (reg_idx)
            REG_DELAY:  prdata = DATA_WIDTH'(delay_reg);
            REG_RISE:   prdata = DATA_WIDTH'(rise_reg);
            REG_WIDTH:  prdata = DATA_WIDTH'(width_reg);
            REG_FALL:   prdata = DATA_WIDTH'(fall_reg);
            REG_PERIOD: prdata = DATA_WIDTH'(period_reg);
            REG_LOW:    prdata = DATA_WIDTH'(low_reg);
            REG_HIGH:   prdata = DATA_WIDTH'(high_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: hold one request, advance the period, pick the phase.
    // ------------------------------------------------------------------
    pswf_front #(
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .sim_time      (sim_time),
        .delay_load    (delay_load),
        .delay_value   (wr_time),
        .delay_time    (delay_reg),
        .rise_time     (rise_reg),
        .pulse_width   (width_reg),
        .fall_time     (fall_reg),
        .period_length (period_reg),
        .cmd_valid     (f_cmd_valid),
        .cmd_full      (q_full),
        .cmd_kind      (f_kind),
        .cmd_elapsed   (f_elapsed),
        .cmd_dur       (f_dur)
    );

    // ------------------------------------------------------------------
    // Queue: lets the classifier run ahead while a ramp is being divided.
    // ------------------------------------------------------------------
    pswf_queue #(
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (f_cmd_valid),
        .full         (q_full),
        .push_kind    (f_kind),
        .push_elapsed (f_elapsed),
        .push_dur     (f_dur),
        .pop          (q_pop),
        .empty        (q_empty),
        .pop_kind     (q_kind),
        .pop_elapsed  (q_elapsed),
        .pop_dur      (q_dur)
    );

    // ------------------------------------------------------------------
    // Back: level select or ramp interpolation, then the result register.
    // A new command starts while the previous result still waits for pop.
    // ------------------------------------------------------------------
    pswf_back #(
        .TIME_WIDTH   (TIME_WIDTH),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (q_empty),
        .cmd_pop      (q_pop),
        .cmd_kind     (q_kind),
        .cmd_elapsed  (q_elapsed),
        .cmd_dur      (q_dur),
        .low_level    (low_reg),
        .high_level   (high_reg),
        .empty        (empty),
        .pop          (pop),
        .source_value (source_value)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_front_one_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full
    ) else $error("classifier did not close after taking a request");

    a_pop_only_when_filled: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty
    ) else $error("ramp engine popped an empty queue");

    a_queue_flags_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(q_empty && q_full)
    ) else $error("queue reports empty and full together");

endmodule

`default_nettype wire
